FILE: rtl/rgbcf_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - shared package
// Types, register indexes, sequencer states and default sizes of the filter.
// ----------------------------------------------------------------------------
package rgbcf_pkg;

  localparam int unsigned DefMaxWidth     = 1024;
  localparam int unsigned DefMaxHeight    = 1024;
  localparam int unsigned DefChannelBits  = 16;
  localparam int unsigned DefCoefFracBits = 8;

  localparam int unsigned CoefBits    = 16;
  localparam int unsigned KernelBits  = 48;
  localparam int unsigned CfgDataBits = 48;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned DimBits     = 11;
  localparam int unsigned ColorBits   = 16;
  // Magnitude of the summed weight of nine coefficients fits in 20 bits.
  localparam int unsigned DenBits     = 20;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_KERNEL_TOP   = 3'd0,
    CFG_KERNEL_MID   = 3'd1,
    CFG_KERNEL_BOT   = 3'd2,
    CFG_NORMALIZE    = 3'd3,
    CFG_MAX_COLOR    = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                 req_type;
    logic [ColorBits-1:0] in_red;
    logic [ColorBits-1:0] in_green;
    logic [ColorBits-1:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [ColorBits-1:0] out_red;
    logic [ColorBits-1:0] out_green;
    logic [ColorBits-1:0] out_blue;
    logic                 last_of_frame;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_RS_COL,
    ST_RS_COL_W,
    ST_RS_POS,
    ST_RS_POS_W,
    ST_FRAME,
    ST_DECIDE,
    ST_LOOP,
    ST_SH_RD,
    ST_SH_WR,
    ST_POST,
    ST_MAC_CLR,
    ST_MAC,
    ST_MAC_END,
    ST_FIN,
    ST_FIN_W,
    ST_OUT
  } state_e;

  // Picks coefficient k (0 left, 1 centre, 2 right) out of a kernel row.
  function automatic logic signed [CoefBits-1:0] coef_at(
    input logic [KernelBits-1:0] row,
    input logic [1:0]            k
  );
    logic signed [CoefBits-1:0] c;
    unique case (k)
      2'd0:    c = row[15:0];
      2'd1:    c = row[31:16];
      default: c = row[47:32];
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/rgbcf_div.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgbcf_div #(
  parameter int unsigned DIV_W = 37,
  parameter int unsigned DEN_W = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CntBits = $clog2(DIV_W + 1);

  logic               busy_q, done_q;
  logic [CntBits-1:0] cnt_q;
  logic [DIV_W-1:0]   quot_q;
  logic [DEN_W-1:0]   rem_q, den_q;
  logic [DEN_W:0]     trial, diff;
  logic               ge;

  always_comb begin
    trial = {rem_q, quot_q[DIV_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntBits'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_q <= {quot_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/rgbcf_line_mem.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - line memories
// Two row stores sharing one column address, registered read data.
// ----------------------------------------------------------------------------
module rgbcf_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned PIX_W = 48
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [PIX_W-1:0]         older_wd_i,
  input  logic [PIX_W-1:0]         newer_wd_i,
  output logic [PIX_W-1:0]         older_rd_o,
  output logic [PIX_W-1:0]         newer_rd_o
);

  logic [PIX_W-1:0] older_mem [DEPTH];
  logic [PIX_W-1:0] newer_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      older_mem[addr_i] <= older_wd_i;
      newer_mem[addr_i] <= newer_wd_i;
    end
    older_rd_o <= older_mem[addr_i];
    newer_rd_o <= newer_mem[addr_i];
  end

endmodule

FILE: rtl/rgb_3x3_convolution_filter_top.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - top level
// Streams RGB pixels in raster order through a 3x3 kernel per channel.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Word
//   input    in         in_valid_i / in_ready_o   in_data_i  (in_word_t)
//   output   out        out_valid_o / out_ready_i out_data_o (out_word_t)
//   config   in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A pixel word shifts its pixel into the window; a drain step shifts in
// zeros instead. A word that produces a result also runs the shared
// multiply-accumulate (27 products) and the hand-off to the output
// register, and the shared radix-2 divider runs once for each channel
// that needs a division.
// The first word after a write of image_width re-derives the column
// counters with the same divider.
// Reset is asynchronous; the line memories are not cleared.
// A stalled output word holds while the next input word is already taken.
module rgb_3x3_convolution_filter_top #(
  parameter int unsigned MAX_WIDTH      = rgbcf_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT     = rgbcf_pkg::DefMaxHeight,
  parameter int unsigned CHANNEL_BITS   = rgbcf_pkg::DefChannelBits,
  parameter int unsigned COEF_FRAC_BITS = rgbcf_pkg::DefCoefFracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rgbcf_pkg::in_word_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rgbcf_pkg::out_word_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [rgbcf_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [rgbcf_pkg::CfgDataBits-1:0]   cfg_data_i
);

  import rgbcf_pkg::*;

  localparam int unsigned ColW     = $clog2(MAX_WIDTH);
  localparam int unsigned WW       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW       = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RowW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned TotW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned CntW     = TotW + 2;
  localparam int unsigned PixW     = 3 * CHANNEL_BITS;
  localparam int unsigned ProdW    = CHANNEL_BITS + CoefBits + 1;
  localparam int unsigned AccW     = ProdW + 4;
  localparam int unsigned WsumW    = CoefBits + 4;
  localparam int unsigned DivW     = (AccW > CntW) ? AccW : CntW;
  localparam int unsigned GuardLim = 2 * MAX_WIDTH + 4;
  localparam int unsigned GuardW   = $clog2(GuardLim + 1);
  localparam int unsigned ChanMax  = (2 ** CHANNEL_BITS) - 1;

  // Configuration registers.
  logic [KernelBits-1:0] ktop_q, kmid_q, kbot_q;
  logic                  norm_q;
  logic [ColorBits-1:0]  maxc_q;
  logic [DimBits-1:0]    iw_q, ih_q;
  logic                  resync_q, resync_clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ktop_q   <= '0;
      kmid_q   <= '0;
      kbot_q   <= '0;
      norm_q   <= 1'b0;
      maxc_q   <= ColorBits'(255);
      iw_q     <= DimBits'(1024);
      ih_q     <= DimBits'(1024);
      resync_q <= 1'b0;
    end else begin
      if (resync_clr && !(cfg_we_i && (cfg_idx_i == CFG_IMAGE_WIDTH))) begin
        resync_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KERNEL_TOP:   ktop_q <= cfg_data_i[KernelBits-1:0];
          CFG_KERNEL_MID:   kmid_q <= cfg_data_i[KernelBits-1:0];
          CFG_KERNEL_BOT:   kbot_q <= cfg_data_i[KernelBits-1:0];
          CFG_NORMALIZE:    norm_q <= cfg_data_i[0];
          CFG_MAX_COLOR:    maxc_q <= cfg_data_i[ColorBits-1:0];
          CFG_IMAGE_WIDTH: begin
            iw_q     <= cfg_data_i[DimBits-1:0];
            // The column counters follow the old width and must be rebuilt.
            resync_q <= 1'b1;
          end
          CFG_IMAGE_HEIGHT: ih_q <= cfg_data_i[DimBits-1:0];
          default: ;
        endcase
      end
    end
  end

  // Effective frame size: zero counts as one, large values saturate.
  logic [WW-1:0] ew;
  logic [HW-1:0] eh;

  always_comb begin
    if (iw_q == '0) begin
      ew = WW'(1);
    end else if (32'(iw_q) > MAX_WIDTH) begin
      ew = WW'(MAX_WIDTH);
    end else begin
      ew = WW'(iw_q);
    end
    if (ih_q == '0) begin
      eh = HW'(1);
    end else if (32'(ih_q) > MAX_HEIGHT) begin
      eh = HW'(MAX_HEIGHT);
    end else begin
      eh = HW'(ih_q);
    end
  end

  // Sequencer and datapath state.
  state_e state_q, state_d;

  logic [WW-1:0]   ew_q;
  logic [HW-1:0]   eh_q;
  logic [TotW-1:0] tot_q;
  logic [CntW-1:0] accepted_q, emitted_q, shifts_q;
  logic [ColW-1:0] col_q, cx_q;
  logic [RowW-1:0] cy_q;
  logic [GuardW-1:0] guard_q;
  logic [PixW-1:0] win_q [9];
  logic            req_q, pixmode_q;
  logic [1:0]      r_q, k_q, ch_q;
  logic            prod_vld_q, out_valid_q;

  logic [PixW-1:0]           pix_q;
  logic signed [ProdW-1:0]   prod_q;
  logic [1:0]                prod_ch_q;
  logic signed [AccW-1:0]    acc_q [3];
  logic signed [WsumW-1:0]   wsum_q;
  logic [ColorBits-1:0]      res_q [3];
  out_word_t                 out_q;

  // Line memories.
  logic            mem_we;
  logic [PixW-1:0] older_rd, newer_rd, shift_pix;

  assign shift_pix = pixmode_q ? pix_q : '0;

  rgbcf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .PIX_W (PixW)
  ) u_line_mem (
    .clk_i      (clk_i),
    .addr_i     (col_q),
    .we_i       (mem_we),
    .older_wd_i (newer_rd),
    .newer_wd_i (shift_pix),
    .older_rd_o (older_rd),
    .newer_rd_o (newer_rd)
  );

  // Shared divider.
  logic               div_start, div_done;
  logic [DivW-1:0]    div_a, div_quot;
  logic [DenBits-1:0] div_b, div_rem;

  rgbcf_div #(
    .DIV_W (DivW),
    .DEN_W (DenBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Frame bookkeeping.
  logic [CntW-1:0] tot_ext, thr;
  logic            need_shift, drain, frame_done, last_out;

  always_comb begin
    tot_ext    = CntW'(tot_q);
    thr        = emitted_q + CntW'(ew_q) + CntW'(2);
    need_shift = shifts_q < thr;
    drain      = req_q || (accepted_q >= tot_ext);
    frame_done = emitted_q >= tot_ext;
    last_out   = (emitted_q + CntW'(1)) >= tot_ext;
  end

  // Multiply-accumulate operand selection.
  logic                     vr, vk, tap_ok, mac_last;
  logic [KernelBits-1:0]    krow;
  logic signed [CoefBits-1:0] coef;
  logic [3:0]               tap;
  logic [PixW-1:0]          tap_pix;
  logic [CHANNEL_BITS-1:0]  tap_ch;
  logic signed [ProdW-1:0]  prod_d;

  always_comb begin
    unique case (r_q)
      2'd0:    vr = cy_q != '0;
      2'd1:    vr = 1'b1;
      default: vr = (32'(cy_q) + 32'd1) < 32'(eh_q);
    endcase
    unique case (k_q)
      2'd0:    vk = cx_q != '0;
      2'd1:    vk = 1'b1;
      default: vk = (32'(cx_q) + 32'd1) < 32'(ew_q);
    endcase
    tap_ok = vr && vk;
    unique case (r_q)
      2'd0:    krow = ktop_q;
      2'd1:    krow = kmid_q;
      default: krow = kbot_q;
    endcase
    coef    = coef_at(krow, k_q);
    tap     = {2'b00, r_q} * 4'd3 + {2'b00, k_q};
    tap_pix = win_q[tap];
    unique case (ch_q)
      2'd0:    tap_ch = tap_pix[CHANNEL_BITS-1:0];
      2'd1:    tap_ch = tap_pix[2*CHANNEL_BITS-1:CHANNEL_BITS];
      default: tap_ch = tap_pix[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    endcase
    prod_d   = $signed({1'b0, tap_ch}) * coef;
    mac_last = (r_q == 2'd2) && (k_q == 2'd2) && (ch_q == 2'd2);
  end

  // Final scaling of one channel.
  logic signed [AccW-1:0] fin_sum;
  logic [AccW-1:0]        mag_s, sh_val;
  logic [WsumW-1:0]       mag_w;
  logic                   use_div, fin_div;
  logic [DivW-1:0]        direct_val;
  logic [ColorBits-1:0]   lim;

  always_comb begin
    fin_sum = acc_q[ch_q];
    mag_s   = fin_sum[AccW-1] ? AccW'(-fin_sum) : AccW'(fin_sum);
    mag_w   = wsum_q[WsumW-1] ? WsumW'(-wsum_q) : WsumW'(wsum_q);
    sh_val  = AccW'($unsigned(fin_sum) >> COEF_FRAC_BITS);
    use_div = norm_q && (wsum_q != '0);
    // A quotient of opposite signs or of a zero sum clamps to zero anyway.
    fin_div = use_div && (fin_sum != '0) && (fin_sum[AccW-1] == wsum_q[WsumW-1]);
    if (use_div || fin_sum[AccW-1]) begin
      direct_val = '0;
    end else begin
      direct_val = DivW'(sh_val);
    end
    lim = (32'(maxc_q) > ChanMax) ? ColorBits'(ChanMax) : maxc_q;
  end

  function automatic logic [ColorBits-1:0] clamp_to(
    input logic [DivW-1:0]      v,
    input logic [ColorBits-1:0] top
  );
    logic [ColorBits-1:0] r;
    if (v > DivW'(top)) begin
      r = top;
    end else begin
      r = v[ColorBits-1:0];
    end
    return r;
  endfunction

  // Next state and sequencer outputs.
  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    div_a      = DivW'(mag_s);
    div_b      = DenBits'(mag_w);
    mem_we     = 1'b0;
    resync_clr = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = resync_q ? ST_RS_COL : ST_FRAME;
      end
      ST_RS_COL: begin
        div_start = 1'b1;
        div_a     = DivW'(shifts_q);
        div_b     = DenBits'(ew_q);
        state_d   = ST_RS_COL_W;
      end
      ST_RS_COL_W: begin
        if (div_done) state_d = ST_RS_POS;
      end
      ST_RS_POS: begin
        div_start = 1'b1;
        div_a     = DivW'(emitted_q);
        div_b     = DenBits'(ew_q);
        state_d   = ST_RS_POS_W;
      end
      ST_RS_POS_W: begin
        if (div_done) begin
          resync_clr = 1'b1;
          state_d    = ST_FRAME;
        end
      end
      ST_FRAME: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (!drain) begin
          state_d = ST_SH_RD;
        end else if (accepted_q < tot_ext) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (need_shift && (32'(guard_q) < GuardLim)) begin
          state_d = ST_SH_RD;
        end else begin
          state_d = ST_MAC_CLR;
        end
      end
      ST_SH_RD: begin
        state_d = ST_SH_WR;
      end
      ST_SH_WR: begin
        mem_we  = 1'b1;
        state_d = pixmode_q ? ST_POST : ST_LOOP;
      end
      ST_POST: begin
        state_d = need_shift ? ST_IDLE : ST_MAC_CLR;
      end
      ST_MAC_CLR: begin
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (mac_last) state_d = ST_MAC_END;
      end
      ST_MAC_END: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_div) begin
          div_start = 1'b1;
          state_d   = ST_FIN_W;
        end else if (ch_q == 2'd2) begin
          state_d = ST_OUT;
        end
      end
      ST_FIN_W: begin
        if (div_done) state_d = (ch_q == 2'd2) ? ST_OUT : ST_FIN;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers, counters and the window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ew_q        <= '0;
      eh_q        <= '0;
      tot_q       <= '0;
      accepted_q  <= '0;
      emitted_q   <= '0;
      shifts_q    <= '0;
      col_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      guard_q     <= '0;
      req_q       <= 1'b0;
      pixmode_q   <= 1'b0;
      r_q         <= '0;
      k_q         <= '0;
      ch_q        <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      prod_vld_q <= (state_q == ST_MAC) && tap_ok;
      // A new word loaded in ST_OUT takes the place of the one leaving.
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) req_q <= in_data_i.req_type;
        end
        ST_PREP: begin
          ew_q  <= ew;
          eh_q  <= eh;
          tot_q <= TotW'(32'(ew) * 32'(eh));
        end
        ST_RS_COL_W: begin
          if (div_done) col_q <= ColW'(div_rem);
        end
        ST_RS_POS_W: begin
          if (div_done) begin
            cx_q <= ColW'(div_rem);
            cy_q <= RowW'(div_quot);
          end
        end
        ST_FRAME: begin
          if (frame_done) begin
            accepted_q <= '0;
            emitted_q  <= '0;
            shifts_q   <= '0;
            col_q      <= '0;
            cx_q       <= '0;
            cy_q       <= '0;
            for (int i = 0; i < 9; i++) win_q[i] <= '0;
          end
        end
        ST_DECIDE: begin
          pixmode_q <= !drain;
          guard_q   <= '0;
        end
        ST_LOOP: begin
          if (need_shift && (32'(guard_q) < GuardLim)) guard_q <= guard_q + GuardW'(1);
        end
        ST_SH_WR: begin
          for (int r = 0; r < 3; r++) begin
            win_q[r*3]   <= win_q[r*3+1];
            win_q[r*3+1] <= win_q[r*3+2];
          end
          win_q[2] <= older_rd;
          win_q[5] <= newer_rd;
          win_q[8] <= shift_pix;
          if ((32'(col_q) + 32'd1) == 32'(ew_q)) begin
            col_q <= '0;
          end else begin
            col_q <= col_q + ColW'(1);
          end
          shifts_q <= shifts_q + CntW'(1);
          if (pixmode_q) accepted_q <= accepted_q + CntW'(1);
        end
        ST_MAC_CLR: begin
          r_q  <= '0;
          k_q  <= '0;
          ch_q <= '0;
        end
        ST_MAC: begin
          if (ch_q == 2'd2) begin
            ch_q <= '0;
            if (k_q == 2'd2) begin
              k_q <= '0;
              r_q <= r_q + 2'd1;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end else begin
            ch_q <= ch_q + 2'd1;
          end
        end
        ST_MAC_END: begin
          ch_q <= '0;
        end
        ST_FIN: begin
          if (!fin_div && (ch_q != 2'd2)) ch_q <= ch_q + 2'd1;
        end
        ST_FIN_W: begin
          if (div_done && (ch_q != 2'd2)) ch_q <= ch_q + 2'd1;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (last_out) begin
              // End of frame: the next pixel starts a fresh frame.
              accepted_q <= '0;
              emitted_q  <= '0;
              shifts_q   <= '0;
              col_q      <= '0;
              cx_q       <= '0;
              cy_q       <= '0;
              for (int i = 0; i < 9; i++) win_q[i] <= '0;
            end else begin
              emitted_q <= emitted_q + CntW'(1);
              if ((32'(cx_q) + 32'd1) == 32'(ew_q)) begin
                cx_q <= '0;
                cy_q <= cy_q + RowW'(1);
              end else begin
                cx_q <= cx_q + ColW'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      pix_q <= {in_data_i.in_blue[CHANNEL_BITS-1:0], in_data_i.in_green[CHANNEL_BITS-1:0],
                in_data_i.in_red[CHANNEL_BITS-1:0]};
    end
    prod_q    <= prod_d;
    prod_ch_q <= ch_q;
    if (state_q == ST_MAC_CLR) begin
      for (int c = 0; c < 3; c++) acc_q[c] <= '0;
      wsum_q <= '0;
    end else begin
      if (prod_vld_q) acc_q[prod_ch_q] <= acc_q[prod_ch_q] + AccW'(prod_q);
      if ((state_q == ST_MAC) && tap_ok && (ch_q == 2'd0)) begin
        wsum_q <= wsum_q + WsumW'(coef);
      end
    end
    if ((state_q == ST_FIN) && !fin_div) begin
      res_q[ch_q] <= clamp_to(direct_val, lim);
    end
    if ((state_q == ST_FIN_W) && div_done) begin
      res_q[ch_q] <= clamp_to(div_quot, lim);
    end
    if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
      out_q.out_red       <= res_q[0];
      out_q.out_green     <= res_q[1];
      out_q.out_blue      <= res_q[2];
      out_q.last_of_frame <= last_out;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/rgbcf_checker.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - port checker
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module rgbcf_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input rgbcf_pkg::out_word_t out_data_o
);

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // One word at a time: the input closes right after a word is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in work");

  // A new result only appears at the end of work on a word.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without work on a word");

endmodule

bind rgb_3x3_convolution_filter_top rgbcf_checker u_rgbcf_checker (.*);

FILE: tb/filter_checker.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - result checker
// Watches the configuration port and both channels, keeps its own copy of
// the filter state, and compares every output word with the predicted one.
// ----------------------------------------------------------------------------
module filter_checker
  import rgbcf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  in_word_t               in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  out_word_t              out_data_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output int                     mismatches_o,
  output int                     pending_o
);

  localparam int unsigned MaxW = DefMaxWidth;
  localparam int unsigned MaxH = DefMaxHeight;

  // Shadow copy of the configuration registers.
  logic [KernelBits-1:0] krow [3];
  logic                  norm_en;
  logic [ColorBits-1:0]  max_col;
  logic [DimBits-1:0]    img_w, img_h;

  // Shadow copy of the line stores, window and frame counters.
  logic [47:0] row_older [MaxW];
  logic [47:0] row_newer [MaxW];
  logic [47:0] win [9];
  int unsigned n_taken, n_sent, n_shifts;

  out_word_t expected_px[$];

  assign pending_o = expected_px.size();

  initial begin
    mismatches_o = 0;
    for (int i = 0; i < MaxW; i++) begin
      row_older[i] = '0;
      row_newer[i] = '0;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches_o++;
  endtask

  function automatic int unsigned width_eff();
    if (img_w == 0) return 1;
    if (img_w > MaxW) return MaxW;
    return 32'(img_w);
  endfunction

  function automatic int unsigned height_eff();
    if (img_h == 0) return 1;
    if (img_h > MaxH) return MaxH;
    return 32'(img_h);
  endfunction

  task automatic clear_frame();
    n_taken = 0;
    n_sent = 0;
    n_shifts = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
  endtask

  task automatic shift_pixel(input logic [47:0] px, input int unsigned w);
    int unsigned c;
    c = (n_shifts % w) % MaxW;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = row_older[c];
    win[5] = row_newer[c];
    win[8] = px;
    row_older[c] = row_newer[c];
    row_newer[c] = px;
    n_shifts++;
  endtask

  // Weighted sum over the in-frame neighbours of the pixel now leaving.
  function automatic out_word_t filter_pixel(input int unsigned w, input int unsigned h);
    out_word_t res;
    longint sum [3];
    longint wsum, cy, cx, ny, nx, cf, v;
    logic [15:0] ch_val [3];
    sum = '{0, 0, 0};
    wsum = 0;
    cy = n_sent / w;
    cx = n_sent % w;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        ny = cy + r - 1;
        nx = cx + k - 1;
        if (ny >= 0 && ny < h && nx >= 0 && nx < w) begin
          cf = $signed(krow[r][16*k +: 16]);
          for (int ch = 0; ch < 3; ch++)
            sum[ch] += longint'(win[r*3+k][16*ch +: 16]) * cf;
          wsum += cf;
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (norm_en && wsum != 0) v = sum[ch] / wsum;
      else v = sum[ch] / 256;
      if (v > longint'(max_col)) v = longint'(max_col);
      if (v < 0) v = 0;
      ch_val[ch] = v[15:0];
    end
    res.out_red = ch_val[0];
    res.out_green = ch_val[1];
    res.out_blue = ch_val[2];
    res.last_of_frame = 1'b0;
    return res;
  endfunction

  task automatic predict_word(input in_word_t wd);
    int unsigned w, h, total, guard;
    logic drain;
    out_word_t res;
    w = width_eff();
    h = height_eff();
    total = w * h;
    if (n_sent >= total) clear_frame();
    drain = wd.req_type || n_taken >= total;
    if (!drain) begin
      shift_pixel({wd.in_blue, wd.in_green, wd.in_red}, w);
      n_taken++;
      if (n_shifts < n_sent + w + 2) return;
    end else begin
      if (n_taken < total) return;
      guard = 0;
      while (n_shifts < n_sent + w + 2 && guard < 2 * MaxW + 4) begin
        shift_pixel('0, w);
        guard++;
      end
    end
    res = filter_pixel(w, h);
    n_sent++;
    res.last_of_frame = (n_sent >= total);
    if (res.last_of_frame) clear_frame();
    expected_px.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      krow = '{default: '0};
      norm_en = 1'b0;
      max_col = 16'd255;
      img_w = 11'd1024;
      img_h = 11'd1024;
      clear_frame();
      expected_px.delete();
    end else begin
      // Compare first: a result never leaves in the cycle its input arrives.
      if (out_valid_i && out_ready_i) begin
        if (expected_px.size() == 0) begin
          report("unexpected word", 32'(out_data_i.out_red), 32'd0);
        end else begin
          want = expected_px.pop_front();
          if (out_data_i.out_red !== want.out_red)
            report("out_red", 32'(out_data_i.out_red), 32'(want.out_red));
          if (out_data_i.out_green !== want.out_green)
            report("out_green", 32'(out_data_i.out_green), 32'(want.out_green));
          if (out_data_i.out_blue !== want.out_blue)
            report("out_blue", 32'(out_data_i.out_blue), 32'(want.out_blue));
          if (out_data_i.last_of_frame !== want.last_of_frame)
            report("last_of_frame", 32'(out_data_i.last_of_frame),
                   32'(want.last_of_frame));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_KERNEL_TOP:   krow[0] = cfg_data_i;
          CFG_KERNEL_MID:   krow[1] = cfg_data_i;
          CFG_KERNEL_BOT:   krow[2] = cfg_data_i;
          CFG_NORMALIZE:    norm_en = cfg_data_i[0];
          CFG_MAX_COLOR:    max_col = cfg_data_i[15:0];
          CFG_IMAGE_WIDTH:  img_w = cfg_data_i[DimBits-1:0];
          CFG_IMAGE_HEIGHT: img_h = cfg_data_i[DimBits-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_word(in_data_i);
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - testbench top
// Drives frames of random size, kernel and clamp through the filter with
// random idling on both channels; a checker beside the block predicts and
// compares every output word.
// ----------------------------------------------------------------------------
module testbench;
  import rgbcf_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is the deliberate receiver hold below.
  localparam int StallLimit = 20000;
  localparam int HoldCycles = 3000;
  // Quiet cycles before a register write, so a word that produced no
  // result has surely finished inside the block.
  localparam int SettleCycles = 150;
  localparam int TotalItems = 1950;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  in_word_t               in_data_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  out_word_t              out_data_o;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  int mismatches, pending;
  int idle_cycles = 0;
  int items_sent = 0;
  // Set by the stimulus when the receiver should hold off for a long stretch.
  logic hold_request = 1'b0;
  // When set, neither side idles, giving back-to-back stretches.
  logic no_gaps = 1'b0;

  always #5 clk_i = ~clk_i;

  rgb_3x3_convolution_filter_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  filter_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random ready, with one long hold when asked for. The hold is
  // counted here so the sender keeps offering words meanwhile and the block
  // backs up into its input.
  initial begin
    int gap;
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: any accepted word or register write counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("rgb_3x3_convolution_filter_top test failed");
      $finish;
    end
  end

  // Offers one word after a random gap and returns at the edge it is taken.
  // Valid is only lowered when there is a gap, so it never drops and rises
  // within one time step.
  task automatic send_word(input logic req, input logic [47:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{req_type: req, in_red: px[15:0], in_green: px[31:16],
                   in_blue: px[47:32]};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Sender pause until every predicted word has come out, then settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [47:0] kt, input logic [47:0] km,
                           input logic [47:0] kb, input logic norm,
                           input logic [15:0] maxc, input logic [10:0] w,
                           input logic [10:0] h);
    write_reg(CFG_KERNEL_TOP, kt);
    write_reg(CFG_KERNEL_MID, km);
    write_reg(CFG_KERNEL_BOT, kb);
    write_reg(CFG_NORMALIZE, {47'd0, norm});
    write_reg(CFG_MAX_COLOR, {32'd0, maxc});
    write_reg(CFG_IMAGE_WIDTH, {37'd0, w});
    write_reg(CFG_IMAGE_HEIGHT, {37'd0, h});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h0000;
    if (p == 1) return 16'hffff;
    if (p < 5) return 16'($urandom_range(0, 255));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [47:0] rand_pixel();
    return {rand_sample(), rand_sample(), rand_sample()};
  endfunction

  // Coefficients lean toward small positive weights so normalized output
  // is meaningful, with extremes and full-range noise mixed in.
  function automatic logic [15:0] rand_coef();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h7fff;
    if (p == 1) return 16'h8000;
    if (p == 2) return 16'h0000;
    if (p < 7) return 16'($urandom_range(0, 512));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [47:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  // One frame: its pixels, with stray drains mixed in (ignored while the
  // frame is open), then enough tail words to flush it. Some tail words are
  // pixels, which act as drains once the frame is complete.
  task automatic run_frame(input int w, input int h, input logic noisy);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_word(1'b1, rand_pixel());
      send_word(1'b0, rand_pixel());
    end
    for (int i = 0; i < w + 2 + (noisy ? $urandom_range(0, 2) : 0); i++)
      send_word(!(noisy && $urandom_range(0, 9) == 0), rand_pixel());
  endtask

  initial begin
    int w, h;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A mid-size normalizing frame while the receiver holds off, so the
    // block backs up and stalls its input.
    configure(48'h0040_0080_0040, 48'h0080_0100_0080, 48'h0040_0080_0040,
              1'b1, 16'hffff, 11'd20, 11'd6);
    hold_request = 1'b1;
    run_frame(20, 6, 1'b0);
    wait_drained();

    // Directed: one-pixel frame (size zero reads as one), drained with
    // zeros shifted in.
    configure(48'h0000_0100_0000, 48'h0100_0100_0100, 48'h0000_0100_0000,
              1'b0, 16'hffff, 11'd0, 11'd0);
    send_word(1'b1, 48'h0);
    send_word(1'b0, 48'hffff_ffff_ffff);
    send_word(1'b1, 48'h0);
    send_word(1'b1, 48'h0);
    wait_drained();

    // Extremes of samples and coefficients, raw sum, clamp to one.
    configure(48'h8000_7fff_8000, 48'h7fff_8000_7fff, 48'hffff_0001_ffff,
              1'b0, 16'd1, 11'd3, 11'd2);
    for (int i = 0; i < 6; i++) send_word(1'b0, i[0] ? 48'hffff_ffff_ffff : 48'h0);
    for (int i = 0; i < 5; i++) send_word(1'b1, 48'h0);
    wait_drained();

    // Normalizing with a kernel whose nine weights cancel, but within a 2x2
    // frame they do not. Clamp of zero forces every output to zero.
    configure(48'hff00_0100_0000, 48'h0100_0200_ff00, 48'h0000_fe00_0000,
              1'b1, 16'd0, 11'd2, 11'd2);
    for (int i = 0; i < 4; i++) send_word(1'b0, rand_pixel());
    for (int i = 0; i < 4; i++) send_word(1'b1, 48'h0);
    wait_drained();

    // Height above the maximum saturates; a single column tall frame.
    configure(rand_row(), rand_row(), rand_row(), 1'b1, 16'hffff, 11'd1, 11'd2047);
    run_frame(1, 1024, 1'b0);
    wait_drained();

    // Random frames, mostly small, some back to back without idling.
    while (items_sent < TotalItems) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      configure(rand_row(), rand_row(), rand_row(), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 16'(rand_sample()) : 16'd255,
                11'(w), 11'(h));
      no_gaps = ($urandom_range(0, 4) == 0);
      run_frame(w, h, 1'b1);
      wait_drained();
    end

    no_gaps = 1'b0;
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("rgb_3x3_convolution_filter_top test passed");
    end else begin
      $display("rgb_3x3_convolution_filter_top test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rgbcf_pkg.sv
rtl/rgbcf_div.sv
rtl/rgbcf_line_mem.sv
rtl/rgb_3x3_convolution_filter_top.sv
rtl/rgbcf_checker.sv
tb/filter_checker.sv
tb/testbench.sv
